@@ hw/rtl/vector_clock_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the vector clock unit
// Clocked assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef VECTOR_CLOCK_UNIT_ASSERT_SVH
`define VECTOR_CLOCK_UNIT_ASSERT_SVH

`ifndef SYNTH
// check prop on each rising edge, suspended while rst is high
`define VCU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vector clock unit assertion failed");
// check prop on each rising edge, reset included
`define VCU_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("vector clock unit assertion failed");
`else
`define VCU_ASSERT(lbl, clk, rst, prop)
`define VCU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ hw/rtl/vcu_pkg.sv @@
// ---------------------------------------------------------------------------
// Vector clock unit package
// Field widths, operation codes and the ordering flag bundle.
// ---------------------------------------------------------------------------
package vcu_pkg;

   localparam int OP_W    = 3;
   localparam int IDX_W   = 4;
   localparam int VALUE_W = 32;
   localparam int TID_W   = 4;

   // operation codes; the two unused codes behave like a read
   typedef enum logic [OP_W-1:0] {
      OP_LOAD    = 3'd0,
      OP_JOIN    = 3'd1,
      OP_MEET    = 3'd2,
      OP_COMPARE = 3'd3,
      OP_ADVANCE = 3'd4,
      OP_READ    = 3'd5
   } op_type;

   // ordering and overflow flags of one result beat
   typedef struct packed {
      logic before_res;
      logic after;
      logic equal;
      logic concurrent;
      logic strictly_concurrent;
      logic ordered_less;
      logic overflow;
   } flags_type;

endpackage

@@ hw/rtl/vcu_req_if.sv @@
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one clock element or command per beat.
// ---------------------------------------------------------------------------
interface vcu_req_if;
   logic                        valid;
   logic                        ready;
   logic [vcu_pkg::OP_W-1:0]    op;
   logic [vcu_pkg::IDX_W-1:0]   index;
   logic [vcu_pkg::VALUE_W-1:0] value;
   logic [vcu_pkg::TID_W-1:0]   other_thread;
   logic                        last;

   modport source (output valid, op, index, value, other_thread, last, input ready);
   modport sink   (input valid, op, index, value, other_thread, last, output ready);
endinterface

@@ hw/rtl/vcu_rsp_if.sv @@
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat per request beat.
// ---------------------------------------------------------------------------
interface vcu_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [vcu_pkg::VALUE_W-1:0] read_value;
   logic                        before_res;
   logic                        after;
   logic                        equal;
   logic                        concurrent;
   logic                        strictly_concurrent;
   logic                        ordered_less;
   logic                        overflow;

   modport source (output valid, read_value, before_res, after, equal, concurrent,
                   strictly_concurrent, ordered_less, overflow, input ready);
   modport sink   (input valid, read_value, before_res, after, equal, concurrent,
                   strictly_concurrent, ordered_less, overflow, output ready);
endinterface

@@ hw/rtl/vcu_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
module vcu_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en_a,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic             rd_en_b,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write, and register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hw/rtl/vcu_datapath.sv @@
// ---------------------------------------------------------------------------
// Vector clock element datapath
// Computes the write-back value, the compare accumulators and the flags
// for one element against the stored entry.
// ---------------------------------------------------------------------------
module vcu_datapath #(
   parameter int CLOCK_BITS = 32
) (
   input  logic [vcu_pkg::OP_W-1:0] op,
   input  logic [CLOCK_BITS-1:0]    elem,
   input  logic [CLOCK_BITS-1:0]    stored,
   input  logic                     entry_ok,
   input  logic                     last,
   input  logic                     own_lt_other,
   input  logic                     saw_gt,
   input  logic                     saw_ls,
   output logic                     wr_en,
   output logic [CLOCK_BITS-1:0]    wr_data,
   output logic                     saw_gt_in,
   output logic                     saw_ls_in,
   output vcu_pkg::flags_type       flags
);

   localparam logic [CLOCK_BITS-1:0] ENTRY_MAX = '1;

   logic gt;
   logic ls;
   logic acc_gt;
   logic acc_ls;

   assign gt     = elem > stored;
   assign ls     = elem < stored;
   assign acc_gt = saw_gt | (entry_ok & gt);
   assign acc_ls = saw_ls | (entry_ok & ls);

   // decode the operation
   always_comb begin
      wr_en     = 1'b0;
      wr_data   = elem;
      saw_gt_in = saw_gt;
      saw_ls_in = saw_ls;
      flags     = '0;
      case (op)
         vcu_pkg::OP_LOAD: begin
            wr_en = entry_ok;
         end
         vcu_pkg::OP_JOIN: begin
            wr_en = entry_ok & gt;
         end
         vcu_pkg::OP_MEET: begin
            wr_en = entry_ok & ls;
         end
         vcu_pkg::OP_COMPARE: begin
            if (last) begin
               flags.before_res          = acc_gt & ~acc_ls;
               flags.after               = acc_ls & ~acc_gt;
               flags.equal               = ~acc_gt & ~acc_ls;
               flags.concurrent          = ~(acc_gt ^ acc_ls);
               flags.strictly_concurrent = acc_gt & acc_ls;
               flags.ordered_less        = (acc_gt & acc_ls) ? own_lt_other
                                                             : (acc_gt & ~acc_ls);
               saw_gt_in = 1'b0;
               saw_ls_in = 1'b0;
            end else begin
               saw_gt_in = acc_gt;
               saw_ls_in = acc_ls;
            end
         end
         vcu_pkg::OP_ADVANCE: begin
            // saturate at the top value and flag it
            wr_data = stored + CLOCK_BITS'(1);
            if (entry_ok) begin
               if (stored == ENTRY_MAX) begin
                  flags.overflow = 1'b1;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hw/rtl/vector_clock_unit.sv @@
// Vector clock unit: a request beat is read from the RAM when accepted; the execute
// state then writes back and loads the response register once that register is free.
// A new request is taken only once that beat has committed, also while its response waits.
// Reset (synchronous, active high) clears the owner id, the compare
// accumulators and the per-entry valid bits at once, so every entry reads as
// zero right after reset; no clearing pass is needed.
// ---------------------------------------------------------------------------
// Vector clock unit top level
// Holds one vector clock in a RAM and applies load, join, meet, compare,
// advance and read beats to it, one element at a time.
// ---------------------------------------------------------------------------
`include "vector_clock_unit_assert.svh"

module vector_clock_unit #(
   parameter int THREADS    = 16,
   parameter int CLOCK_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [vcu_pkg::TID_W-1:0] csr_wdata,
   vcu_req_if.sink                   req_ch,
   vcu_rsp_if.source                 rsp_ch
);

   localparam int AW  = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int VW  = vcu_pkg::VALUE_W;
   localparam int IW  = vcu_pkg::IDX_W;
   localparam int TW  = vcu_pkg::TID_W;

   typedef enum logic {S_IDLE, S_EXEC} state_type;

   state_type                state_ff;
   logic [TW-1:0]            own_thread_ff;
   logic                     saw_gt_ff;
   logic                     saw_ls_ff;
   logic [THREADS-1:0]       vld_ff;

   // captured request
   logic [vcu_pkg::OP_W-1:0] op_ff;
   logic [CLOCK_BITS-1:0]    elem_ff;
   logic                     last_ff;
   logic                     own_lt_ff;
   logic                     idx_ok_ff;
   logic                     tgt_ok_ff;
   logic [AW-1:0]            idx_addr_ff;
   logic [AW-1:0]            tgt_addr_ff;

   // response register
   logic                     rsp_valid_ff;
   logic [VW-1:0]            rsp_value_ff;
   vcu_pkg::flags_type       rsp_flags_ff;

   logic                     req_fire;
   logic                     commit;
   logic                     idx_ok;
   logic                     own_ok;
   logic [AW+IW-1:0]         idx_wide;
   logic [AW+TW-1:0]         own_wide;
   logic [AW-1:0]            idx_addr;
   logic [AW-1:0]            own_addr;
   logic [AW-1:0]            tgt_addr;
   logic [CLOCK_BITS+VW-1:0] elem_wide;
   logic [CLOCK_BITS-1:0]    rd_a;
   logic [CLOCK_BITS-1:0]    rd_b;
   logic [CLOCK_BITS-1:0]    stored;
   logic [CLOCK_BITS-1:0]    other_entry;
   logic [CLOCK_BITS-1:0]    result_entry;
   logic [CLOCK_BITS+VW-1:0] result_wide;
   logic                     dp_wr_en;
   logic [CLOCK_BITS-1:0]    dp_wr_data;
   logic                     saw_gt_in;
   logic                     saw_ls_in;
   vcu_pkg::flags_type       dp_flags;
   logic                     ram_we;

   // request side: one element in flight
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign commit       = (state_ff == S_EXEC) & (~rsp_valid_ff | rsp_ch.ready);

   // map ids onto RAM addresses
   assign idx_ok    = 32'(req_ch.index) < THREADS;
   assign own_ok    = 32'(own_thread_ff) < THREADS;
   assign idx_wide  = {{AW{1'b0}}, req_ch.index};
   assign own_wide  = {{AW{1'b0}}, own_thread_ff};
   assign idx_addr  = idx_wide[AW-1:0];
   assign own_addr  = own_wide[AW-1:0];
   assign tgt_addr  = (req_ch.op == vcu_pkg::OP_ADVANCE) ? own_addr : idx_addr;
   assign elem_wide = {{CLOCK_BITS{1'b0}}, req_ch.value};

   // entries never written read as zero
   assign stored      = vld_ff[tgt_addr_ff] ? rd_a : '0;
   assign other_entry = vld_ff[idx_addr_ff] ? rd_b : '0;

   vcu_ram #(
      .WIDTH (CLOCK_BITS),
      .DEPTH (THREADS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (tgt_addr_ff),
      .wr_data   (dp_wr_data),
      .rd_en_a   (req_fire),
      .rd_addr_a (tgt_addr),
      .rd_data_a (rd_a),
      .rd_en_b   (req_fire),
      .rd_addr_b (idx_addr),
      .rd_data_b (rd_b)
   );

   vcu_datapath #(
      .CLOCK_BITS (CLOCK_BITS)
   ) u_datapath (
      .op           (op_ff),
      .elem         (elem_ff),
      .stored       (stored),
      .entry_ok     (tgt_ok_ff),
      .last         (last_ff),
      .own_lt_other (own_lt_ff),
      .saw_gt       (saw_gt_ff),
      .saw_ls       (saw_ls_ff),
      .wr_en        (dp_wr_en),
      .wr_data      (dp_wr_data),
      .saw_gt_in    (saw_gt_in),
      .saw_ls_in    (saw_ls_in),
      .flags        (dp_flags)
   );

   assign ram_we = commit & dp_wr_en;

   // forward the written value when the read entry is the one updated
   always_comb begin
      if (tgt_addr_ff == idx_addr_ff) begin
         result_entry = dp_wr_en ? dp_wr_data : stored;
      end else begin
         result_entry = other_entry;
      end
   end
   assign result_wide = {{VW{1'b0}}, result_entry};

   // control, capture and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         own_thread_ff <= '0;
         saw_gt_ff     <= 1'b0;
         saw_ls_ff     <= 1'b0;
         vld_ff        <= '0;
      end else begin
         if (csr_we) begin
            own_thread_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ch.ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff       <= req_ch.op;
                  elem_ff     <= elem_wide[CLOCK_BITS-1:0];
                  last_ff     <= req_ch.last;
                  own_lt_ff   <= own_thread_ff < req_ch.other_thread;
                  idx_ok_ff   <= idx_ok;
                  tgt_ok_ff   <= (req_ch.op == vcu_pkg::OP_ADVANCE) ? own_ok : idx_ok;
                  idx_addr_ff <= idx_addr;
                  tgt_addr_ff <= tgt_addr;
                  state_ff    <= S_EXEC;
               end
            end
            S_EXEC: begin
               // hold until the response register is free
               if (commit) begin
                  saw_gt_ff    <= saw_gt_in;
                  saw_ls_ff    <= saw_ls_in;
                  if (dp_wr_en) begin
                     vld_ff[tgt_addr_ff] <= 1'b1;
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= idx_ok_ff ? result_wide[VW-1:0] : '0;
                  rsp_flags_ff <= dp_flags;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // drive the response channel
   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.read_value          = rsp_value_ff;
   assign rsp_ch.before_res          = rsp_flags_ff.before_res;
   assign rsp_ch.after               = rsp_flags_ff.after;
   assign rsp_ch.equal               = rsp_flags_ff.equal;
   assign rsp_ch.concurrent          = rsp_flags_ff.concurrent;
   assign rsp_ch.strictly_concurrent = rsp_flags_ff.strictly_concurrent;
   assign rsp_ch.ordered_less        = rsp_flags_ff.ordered_less;
   assign rsp_ch.overflow            = rsp_flags_ff.overflow;

   // an accepted beat moves to execute
   `VCU_ASSERT(a_fire_exec, clock, reset, req_fire |=> (state_ff == S_EXEC))
   // the RAM is written only when the response is loaded
   `VCU_ASSERT_ALWAYS(a_write_commit, clock, ram_we |-> (commit && !reset))
   // a written entry is marked valid
   `VCU_ASSERT(a_write_valid, clock, reset, ram_we |=> vld_ff[$past(tgt_addr_ff)])
   // the closing compare beat clears both accumulators
   `VCU_ASSERT(a_acc_clear, clock, reset,
      (commit && op_ff == vcu_pkg::OP_COMPARE && last_ff) |=> (!saw_gt_ff && !saw_ls_ff))

endmodule

@@ tb/sv/vector_clock_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vector clock unit testbench
// Drives element and command beats into the unit and checks every response
// beat against an in-bench model of the clock vector and the compare state.
// A short table covers extremes, every operation and the ordering outcomes.
// Randomized phases follow, each under its own owner id, with random stalls
// on both channels.
// ---------------------------------------------------------------------------
module vector_clock_unit_test;

   localparam int          ENTRIES     = 16;
   localparam int          STALL_LIMIT = 2000;
   localparam int          PHASES      = 6;
   localparam int          PHASE_BEATS = 125;
   localparam int          TAIL_CYCLES = 8;
   localparam logic [vcu_pkg::VALUE_W-1:0] ENTRY_MAX = '1;

   // unused operation codes; the unit treats them as a read
   localparam logic [vcu_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [vcu_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

   // direction of a generated value relative to the stored entry
   localparam int LEAN_SAME = 0;
   localparam int LEAN_UP   = 1;
   localparam int LEAN_DOWN = 2;
   localparam int LEAN_WILD = 3;

   typedef struct packed {
      logic [vcu_pkg::OP_W-1:0]    op;
      logic [vcu_pkg::IDX_W-1:0]   index;
      logic [vcu_pkg::VALUE_W-1:0] value;
      logic [vcu_pkg::TID_W-1:0]   tid;
      logic                        last;
   } vc_beat_type;

   typedef struct packed {
      logic [vcu_pkg::VALUE_W-1:0] read_value;
      vcu_pkg::flags_type          flags;
   } vc_readout_type;

   typedef struct packed {
      vc_beat_type    beat;
      logic           golden;
      vc_readout_type want;
   } vc_row_type;

   localparam vcu_pkg::flags_type NO_FLAGS = '0;
   localparam vcu_pkg::flags_type OVF_ONLY = '{overflow: 1'b1, default: 1'b0};
   localparam int                 NUM_ROWS = 26;

   // directed rows, run with owner 0 straight after reset
   localparam vc_row_type DIRECTED [NUM_ROWS] = '{
      // reset contents, ignored fields at their maximum
      '{'{vcu_pkg::OP_READ,    4'd0,  32'h0000_0000, 4'd0,  1'b0}, 1'b1,
        '{32'h0000_0000, NO_FLAGS}},
      '{'{vcu_pkg::OP_READ,    4'd15, 32'hFFFF_FFFF, 4'd15, 1'b1}, 1'b1,
        '{32'h0000_0000, NO_FLAGS}},
      // saturation of the owner entry
      '{'{vcu_pkg::OP_LOAD,    4'd0,  32'hFFFF_FFFF, 4'd0,  1'b0}, 1'b1,
        '{32'hFFFF_FFFF, NO_FLAGS}},
      '{'{vcu_pkg::OP_ADVANCE, 4'd0,  32'h0000_0000, 4'd0,  1'b0}, 1'b1,
        '{32'hFFFF_FFFF, OVF_ONLY}},
      '{'{vcu_pkg::OP_LOAD,    4'd0,  32'h0000_0000, 4'd0,  1'b0}, 1'b1,
        '{32'h0000_0000, NO_FLAGS}},
      // advance ignores value, other thread and last; index only picks the readout
      '{'{vcu_pkg::OP_ADVANCE, 4'd5,  32'hFFFF_FFFF, 4'd15, 1'b1}, 1'b1,
        '{32'h0000_0000, NO_FLAGS}},
      '{'{vcu_pkg::OP_READ,    4'd0,  32'h0000_0000, 4'd0,  1'b0}, 1'b0, '0},
      // join keeps the max, meet the min
      '{'{vcu_pkg::OP_LOAD,    4'd15, 32'h8000_0000, 4'd0,  1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_JOIN,    4'd15, 32'h7FFF_FFFF, 4'd0,  1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_JOIN,    4'd15, 32'hFFFF_FFFE, 4'd0,  1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_MEET,    4'd15, 32'h0000_0005, 4'd0,  1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_MEET,    4'd15, 32'h0000_0009, 4'd0,  1'b0}, 1'b0, '0},
      // equal, before, after
      '{'{vcu_pkg::OP_COMPARE, 4'd0,  32'h0000_0001, 4'd3,  1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_COMPARE, 4'd15, 32'h0000_0005, 4'd3,  1'b1}, 1'b0, '0},
      '{'{vcu_pkg::OP_COMPARE, 4'd3,  32'h0000_0002, 4'd0,  1'b1}, 1'b0, '0},
      '{'{vcu_pkg::OP_COMPARE, 4'd15, 32'h0000_0000, 4'd0,  1'b1}, 1'b0, '0},
      // strictly concurrent, tie break both ways
      '{'{vcu_pkg::OP_COMPARE, 4'd3,  32'h0000_0009, 4'd15, 1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_COMPARE, 4'd15, 32'h0000_0000, 4'd15, 1'b1}, 1'b0, '0},
      '{'{vcu_pkg::OP_COMPARE, 4'd3,  32'h0000_0009, 4'd0,  1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_COMPARE, 4'd15, 32'h0000_0000, 4'd0,  1'b1}, 1'b0, '0},
      // accumulators survive an interleaved load that carries last
      '{'{vcu_pkg::OP_COMPARE, 4'd1,  32'h0000_0005, 4'd0,  1'b0}, 1'b0, '0},
      '{'{vcu_pkg::OP_LOAD,    4'd1,  32'h0000_0007, 4'd0,  1'b1}, 1'b0, '0},
      '{'{vcu_pkg::OP_COMPARE, 4'd2,  32'h0000_0000, 4'd0,  1'b1}, 1'b0, '0},
      // unused codes
      '{'{OP_SPARE_A,          4'd15, 32'hAAAA_AAAA, 4'd10, 1'b1}, 1'b0, '0},
      '{'{OP_SPARE_B,          4'd0,  32'h5555_5555, 4'd5,  1'b0}, 1'b0, '0},
      // single element compare, the rest counts as equal
      '{'{vcu_pkg::OP_COMPARE, 4'd7,  32'h0000_0000, 4'd9,  1'b1}, 1'b0, '0}
   };

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [vcu_pkg::TID_W-1:0] csr_wdata;

   vcu_req_if req_ch ();
   vcu_rsp_if rsp_ch ();

   vector_clock_unit #(
      .THREADS    (ENTRIES),
      .CLOCK_BITS (vcu_pkg::VALUE_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   // model state
   logic [vcu_pkg::VALUE_W-1:0] vc_entry [ENTRIES];
   logic                        vc_greater;
   logic                        vc_less;
   logic [vcu_pkg::TID_W-1:0]   vc_owner;

   vc_readout_type expected_readout [$];
   int unsigned    errors;
   bit             steady;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // apply one beat to the model clock and return the response it should give
   function automatic vc_readout_type vclock_apply(input vc_beat_type b);
      vc_readout_type r;
      r = '0;
      // with 16 entries every index and owner id is in range
      case (b.op)
         vcu_pkg::OP_LOAD: vc_entry[b.index] = b.value;
         vcu_pkg::OP_JOIN: if (b.value > vc_entry[b.index]) vc_entry[b.index] = b.value;
         vcu_pkg::OP_MEET: if (b.value < vc_entry[b.index]) vc_entry[b.index] = b.value;
         vcu_pkg::OP_COMPARE: begin
            if (b.value > vc_entry[b.index]) vc_greater = 1'b1;
            if (b.value < vc_entry[b.index]) vc_less = 1'b1;
            if (b.last) begin
               r.flags.before_res          = vc_greater && !vc_less;
               r.flags.after               = vc_less && !vc_greater;
               r.flags.equal               = !vc_greater && !vc_less;
               r.flags.concurrent          = !r.flags.before_res && !r.flags.after;
               r.flags.strictly_concurrent = r.flags.concurrent && !r.flags.equal;
               r.flags.ordered_less        = r.flags.strictly_concurrent ?
                                             (vc_owner < b.tid) : r.flags.before_res;
               vc_greater = 1'b0;
               vc_less    = 1'b0;
            end
         end
         vcu_pkg::OP_ADVANCE: begin
            if (vc_entry[vc_owner] == ENTRY_MAX) r.flags.overflow = 1'b1;
            else vc_entry[vc_owner] = vc_entry[vc_owner] + 1'b1;
         end
         default: ;
      endcase
      r.read_value = vc_entry[b.index];
      return r;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [vcu_pkg::VALUE_W-1:0] want,
                                       input logic [vcu_pkg::VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_bit(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // value close to a stored entry, or anywhere
   function automatic logic [vcu_pkg::VALUE_W-1:0] lean(
      input logic [vcu_pkg::VALUE_W-1:0] base, input int dir);
      logic [vcu_pkg::VALUE_W-1:0] stride;
      stride = $urandom_range(1, 3);
      case (dir)
         LEAN_UP:   return (base > ENTRY_MAX - stride) ? ENTRY_MAX : base + stride;
         LEAN_DOWN: return (base < stride) ? '0 : base - stride;
         LEAN_WILD: return $urandom();
         default:   return base;
      endcase
   endfunction

   function automatic vc_beat_type noise_beat();
      vc_beat_type b;
      int unsigned pick;
      pick    = $urandom_range(7);
      b.op    = pick[vcu_pkg::OP_W-1:0];
      pick    = $urandom_range(15);
      b.index = pick[vcu_pkg::IDX_W-1:0];
      b.value = $urandom();
      pick    = $urandom_range(15);
      b.tid   = pick[vcu_pkg::TID_W-1:0];
      b.last  = ($urandom_range(1) != 0);
      return b;
   endfunction

   // present one beat, hold it until taken, then record what it should return
   task automatic send_beat(input vc_beat_type b, input bit use_want,
                            input vc_readout_type want);
      vc_readout_type predicted;
      while (!steady && $urandom_range(99) < 28) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= $urandom();
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.op           <= b.op;
      req_ch.index        <= b.index;
      req_ch.value        <= b.value;
      req_ch.other_thread <= b.tid;
      req_ch.last         <= b.last;
      do @(posedge clock); while (!req_ch.ready);
      predicted = vclock_apply(b);
      expected_readout.push_back(use_want ? want : predicted);
   endtask

   // drop valid and wait for every outstanding response
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_readout.size() != 0) @(posedge clock);
   endtask

   task automatic write_owner(input logic [vcu_pkg::TID_W-1:0] tid);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= tid;
      @(posedge clock);
      csr_we   <= 1'b0;
      vc_owner  = tid;
   endtask

   task automatic run_phase(input int unsigned beats);
      int unsigned sent;
      int unsigned span;
      int unsigned pick;
      int          trend;
      vc_beat_type b;
      sent = 0;
      while (sent < beats) begin
         b = noise_beat();
         case ($urandom_range(9))
            // well-formed compare sequence, sometimes over the whole vector
            0, 1, 2, 3: begin
               span  = ($urandom_range(7) == 0) ? ENTRIES : $urandom_range(1, 5);
               trend = $urandom_range(LEAN_SAME, LEAN_WILD);
               for (int k = 0; k < span; k++) begin
                  // break the sequence now and then with a stray beat
                  if ($urandom_range(11) == 0) begin
                     send_beat(noise_beat(), 1'b0, '0);
                     sent++;
                  end
                  pick    = (span == ENTRIES) ? k : $urandom_range(15);
                  b.op    = vcu_pkg::OP_COMPARE;
                  b.index = pick[vcu_pkg::IDX_W-1:0];
                  b.value = lean(vc_entry[b.index],
                                 ($urandom_range(2) == 0) ? LEAN_SAME : trend);
                  b.last  = (k == span - 1);
                  send_beat(b, 1'b0, '0);
                  sent++;
               end
            end
            // drive the owner entry up to saturation
            4: begin
               b.op    = vcu_pkg::OP_LOAD;
               b.index = vc_owner;
               b.value = ENTRY_MAX - $urandom_range(0, 2);
               send_beat(b, 1'b0, '0);
               sent++;
               repeat ($urandom_range(1, 4)) begin
                  b = noise_beat();
                  b.op = vcu_pkg::OP_ADVANCE;
                  send_beat(b, 1'b0, '0);
                  sent++;
               end
            end
            // pure noise
            5: begin
               send_beat(b, 1'b0, '0);
               sent++;
            end
            // single op with a value at an extreme, near the stored entry or random
            default: begin
               case ($urandom_range(4))
                  0:       b.value = '0;
                  1:       b.value = ENTRY_MAX;
                  2:       b.value = lean(vc_entry[b.index], $urandom_range(LEAN_UP, LEAN_DOWN));
                  default: b.value = $urandom();
               endcase
               send_beat(b, 1'b0, '0);
               sent++;
            end
         endcase
      end
   endtask

   // response side: random stalls, check each beat against the oldest expectation
   always @(posedge clock) begin
      vc_readout_type seen;
      vc_readout_type want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         seen.read_value                = rsp_ch.read_value;
         seen.flags.before_res          = rsp_ch.before_res;
         seen.flags.after               = rsp_ch.after;
         seen.flags.equal               = rsp_ch.equal;
         seen.flags.concurrent          = rsp_ch.concurrent;
         seen.flags.strictly_concurrent = rsp_ch.strictly_concurrent;
         seen.flags.ordered_less        = rsp_ch.ordered_less;
         seen.flags.overflow            = rsp_ch.overflow;
         if (expected_readout.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            want = expected_readout.pop_front();
            check_field("read_value", want.read_value, seen.read_value);
            check_bit("before_res", want.flags.before_res, seen.flags.before_res);
            check_bit("after", want.flags.after, seen.flags.after);
            check_bit("equal", want.flags.equal, seen.flags.equal);
            check_bit("concurrent", want.flags.concurrent, seen.flags.concurrent);
            check_bit("strictly_concurrent", want.flags.strictly_concurrent,
                      seen.flags.strictly_concurrent);
            check_bit("ordered_less", want.flags.ordered_less, seen.flags.ordered_less);
            check_bit("overflow", want.flags.overflow, seen.flags.overflow);
         end
      end
      rsp_ch.ready <= !reset && (steady || $urandom_range(99) >= 28);
   end

   // end the run when nothing moves on either channel for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("vector_clock_unit_test failed");
      $finish;
   end

   initial begin
      errors = 0;
      steady = 1'b0;
      vc_greater = 1'b0;
      vc_less    = 1'b0;
      vc_owner   = '0;
      foreach (vc_entry[i]) vc_entry[i] = '0;

      reset               <= 1'b1;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.op           <= '0;
      req_ch.index        <= '0;
      req_ch.value        <= '0;
      req_ch.other_thread <= '0;
      req_ch.last         <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i]) send_beat(DIRECTED[i].beat, DIRECTED[i].golden, DIRECTED[i].want);

      // random phases, each under its own owner; one phase runs without stalls
      for (int p = 0; p < PHASES; p++) begin
         write_owner((p == 0) ? 4'd15 : (p == 1) ? 4'd0 : 4'($urandom_range(15)));
         steady = (p == 3);
         run_phase(PHASE_BEATS);
         steady = 1'b0;
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("vector_clock_unit_test passed");
      else
         $display("vector_clock_unit_test failed");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/vcu_pkg.sv
hw/rtl/vcu_req_if.sv
hw/rtl/vcu_rsp_if.sv
hw/rtl/vcu_ram.sv
hw/rtl/vcu_datapath.sv
hw/rtl/vector_clock_unit.sv
tb/sv/vector_clock_unit_test.sv
